### hw/rtl/int8_batch_dot_product_unit_assert.svh
// ----------------------------------------------------------------------------
// int8 batch dot product assertion macros
// shared property forms for the dot product unit
// ----------------------------------------------------------------------------
`ifndef INT8_BATCH_DOT_PRODUCT_UNIT_ASSERT_SVH
`define INT8_BATCH_DOT_PRODUCT_UNIT_ASSERT_SVH

// same-cycle implication
`define I8DP_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("i8dp check failed");

// next-cycle implication
`define I8DP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("i8dp check failed");

`endif

### hw/rtl/i8dp_pkg.sv
// ----------------------------------------------------------------------------
// i8dp package
// shared types and helpers of the int8 batch dot product unit
// ----------------------------------------------------------------------------
package i8dp_pkg;

   localparam int unsigned ACC_W = 32;
   localparam int unsigned LEN_W = 17;
   localparam int unsigned IDX_W = 3;

   // register word index
   localparam logic REG_VECTOR_LENGTH = 1'b0;

   typedef struct packed {
      logic [IDX_W-1:0] lane_index;
      logic             last_result;
   } conv_tag_type;

   // leading zero count by binary halving
   function automatic logic [4:0] lzc32(input logic [31:0] v);
      logic [31:0] x;
      logic [4:0]  n;
      x = v;
      n = '0;
      if (x[31:16] == 16'd0) begin
         n[4] = 1'b1;
         x = {x[15:0], 16'd0};
      end
      if (x[31:24] == 8'd0) begin
         n[3] = 1'b1;
         x = {x[23:0], 8'd0};
      end
      if (x[31:28] == 4'd0) begin
         n[2] = 1'b1;
         x = {x[27:0], 4'd0};
      end
      if (x[31:30] == 2'd0) begin
         n[1] = 1'b1;
         x = {x[29:0], 2'd0};
      end
      if (!x[31]) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

endpackage

### hw/rtl/int8_batch_dot_product_unit.sv
// ----------------------------------------------------------------------------
// int8 batch dot product unit
// one query vector against LANES data vectors, one float result per lane
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req       in   req_tvalid/tready    tdata: query_element, data_lanes
//  rsp       out  rsp_tvalid/tready    tdata: product_sum, tuser: lane_index
//  csr       in   apb, pready high     vector_length at word 0
//
// one item a cycle into the lane multiply-accumulators
// each batch end unloads LANES sums into a result bank, drained one per cycle
// while rsp is not stalled, through a four-stage float converter whose output
// stage drives rsp_tvalid; a batch end waits while the bank holds sums not yet
// issued, so vectors shorter than LANES are paced by the drain of the bank
// synchronous reset clears accumulators, count, bank valid and pipeline valids;
// a stalled rsp holds the whole converter pipeline
// ----------------------------------------------------------------------------
`include "int8_batch_dot_product_unit_assert.svh"

module int8_batch_dot_product_unit #(
   parameter int unsigned LANES = 8
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,    // query_element [7:0], data_lanes [71:8]

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,    // product_sum [31:0]
   output logic [2:0]   rsp_tuser,    // lane_index [2:0]
   output logic         rsp_tlast,

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int unsigned LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int unsigned LEN_W  = i8dp_pkg::LEN_W;
   localparam int unsigned ACC_W  = i8dp_pkg::ACC_W;
   localparam int unsigned IDX_W  = i8dp_pkg::IDX_W;

   logic [LEN_W-1:0]   vlen_ff, vlen_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   count_inc;
   logic [LEN_W-1:0]   len_eff;
   logic               batch_end;
   logic               req_fire;
   logic               csr_wr;

   logic [ACC_W-1:0]   lane_sum [LANES];
   logic [ACC_W-1:0]   bank_ff  [LANES];
   logic               bank_valid_ff, bank_valid_in;
   logic [LANE_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               advance;
   logic               issue;
   logic               issue_last;

   i8dp_pkg::conv_tag_type issue_tag;
   i8dp_pkg::conv_tag_type out_tag;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == i8dp_pkg::REG_VECTOR_LENGTH)
                       ? {{(32-LEN_W){1'b0}}, vlen_ff} : 32'd0;

   always_comb begin
      vlen_in = vlen_ff;
      if (csr_wr && csr_paddr[2] == i8dp_pkg::REG_VECTOR_LENGTH) begin
         vlen_in = csr_pwdata[LEN_W-1:0];
      end
   end

   // element count and batch end
   assign len_eff    = (vlen_ff == '0) ? LEN_W'(1) : vlen_ff;
   assign count_inc  = count_ff + LEN_W'(1);
   assign batch_end  = (count_inc >= len_eff);

   assign advance    = !rsp_tvalid || rsp_tready;
   assign issue      = advance && bank_valid_ff;
   assign issue_last = issue && (rd_idx_ff == LANE_W'(LANES - 1));

   assign req_tready = !batch_end || !bank_valid_ff || issue_last;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         count_in = batch_end ? '0 : count_inc;
      end
   end

   // lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      i8dp_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .acc_en  (req_fire),
         .acc_clr (batch_end),
         .query   (req_tdata[7:0]),
         .data    (req_tdata[8 + 8*g +: 8]),
         .sum     (lane_sum[g])
      );
   end

   // result bank
   always_comb begin
      bank_valid_in = bank_valid_ff;
      rd_idx_in     = rd_idx_ff;
      if (issue) begin
         rd_idx_in = rd_idx_ff + LANE_W'(1);
         if (issue_last) begin
            bank_valid_in = 1'b0;
         end
      end
      if (req_fire && batch_end) begin
         bank_valid_in = 1'b1;
         rd_idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff       <= LEN_W'(1);
         count_ff      <= '0;
         bank_valid_ff <= 1'b0;
         rd_idx_ff     <= '0;
      end else begin
         vlen_ff       <= vlen_in;
         count_ff      <= count_in;
         bank_valid_ff <= bank_valid_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && batch_end) begin
         for (int i = 0; i < LANES; i++) begin
            bank_ff[i] <= lane_sum[i];
         end
      end
   end

   assign issue_tag.lane_index  = IDX_W'(rd_idx_ff);
   assign issue_tag.last_result = (rd_idx_ff == LANE_W'(LANES - 1));

   // float conversion and output register
   i8dp_i2f u_i2f (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (bank_valid_ff),
      .in_value  (bank_ff[rd_idx_ff]),
      .in_tag    (issue_tag),
      .out_valid (rsp_tvalid),
      .out_bits  (rsp_tdata),
      .out_tag   (out_tag)
   );

   assign rsp_tuser = out_tag.lane_index;
   assign rsp_tlast = out_tag.last_result;

   `I8DP_ASSERT_NOW(a_bank_no_overwrite, clock, reset, req_fire && batch_end && bank_valid_ff, issue_last)
   `I8DP_ASSERT_NOW(a_last_on_top_lane, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == 3'(LANES - 1))
   `I8DP_ASSERT_NEXT(a_count_clears, clock, reset, req_fire && batch_end, count_ff == '0 && bank_valid_ff)

endmodule

### hw/rtl/i8dp_lane.sv
// ----------------------------------------------------------------------------
// i8dp lane
// one signed 8x8 multiply-accumulate lane with a 32-bit accumulator
// ----------------------------------------------------------------------------
module i8dp_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc_en,
   input  logic                          acc_clr,
   input  logic signed [7:0]             query,
   input  logic signed [7:0]             data,
   output logic [i8dp_pkg::ACC_W-1:0]    sum
);

   logic signed [15:0]            prod;
   logic [i8dp_pkg::ACC_W-1:0]    acc_ff;
   logic [i8dp_pkg::ACC_W-1:0]    acc_in;

   assign prod = query * data;
   assign sum  = acc_ff + {{(i8dp_pkg::ACC_W-16){prod[15]}}, prod};

   always_comb begin
      acc_in = acc_ff;
      if (acc_en) begin
         acc_in = acc_clr ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

### hw/rtl/i8dp_i2f.sv
// ----------------------------------------------------------------------------
// i8dp integer to float converter
// four-stage pipelined int32 to ieee single, round to nearest even
// ----------------------------------------------------------------------------
module i8dp_i2f (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [31:0]                   in_value,
   input  i8dp_pkg::conv_tag_type        in_tag,
   output logic                          out_valid,
   output logic [31:0]                   out_bits,
   output i8dp_pkg::conv_tag_type        out_tag
);

   // stage 1: sign and magnitude
   logic                    v1_ff, v1_in;
   i8dp_pkg::conv_tag_type  tag1_ff;
   logic                    sign1_ff;
   logic [31:0]             mag1_ff;

   // stage 2: leading zero count
   logic                    v2_ff, v2_in;
   i8dp_pkg::conv_tag_type  tag2_ff;
   logic                    sign2_ff;
   logic                    zero2_ff;
   logic [31:0]             mag2_ff;
   logic [4:0]              lz2_ff;

   // stage 3: normalize
   logic                    v3_ff, v3_in;
   i8dp_pkg::conv_tag_type  tag3_ff;
   logic                    sign3_ff;
   logic                    zero3_ff;
   logic [31:0]             norm3_ff;
   logic [7:0]              exp3_ff;

   // output stage: round and pack
   logic                    vo_ff, vo_in;
   logic [31:0]             bits_ff, bits_in;
   i8dp_pkg::conv_tag_type  tago_ff;

   logic [23:0]             keep;
   logic                    rnd;
   logic [24:0]             rsum;
   logic [7:0]              exp_f;
   logic [22:0]             frac_f;

   assign v1_in = advance ? in_valid : v1_ff;
   assign v2_in = advance ? v1_ff : v2_ff;
   assign v3_in = advance ? v2_ff : v3_ff;
   assign vo_in = advance ? v3_ff : vo_ff;

   always_comb begin
      keep = norm3_ff[31:8];
      rnd  = norm3_ff[7] & ((|norm3_ff[6:0]) | keep[0]);
      rsum = {1'b0, keep} + {24'd0, rnd};
      if (rsum[24]) begin
         exp_f  = exp3_ff + 8'd1;
         frac_f = rsum[23:1];
      end else begin
         exp_f  = exp3_ff;
         frac_f = rsum[22:0];
      end
      bits_in = zero3_ff ? 32'd0 : {sign3_ff, exp_f, frac_f};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag1_ff  <= in_tag;
         sign1_ff <= in_value[31];
         mag1_ff  <= in_value[31] ? (32'd0 - in_value) : in_value;

         tag2_ff  <= tag1_ff;
         sign2_ff <= sign1_ff;
         zero2_ff <= (mag1_ff == 32'd0);
         mag2_ff  <= mag1_ff;
         lz2_ff   <= i8dp_pkg::lzc32(mag1_ff);

         tag3_ff  <= tag2_ff;
         sign3_ff <= sign2_ff;
         zero3_ff <= zero2_ff;
         norm3_ff <= mag2_ff << lz2_ff;
         exp3_ff  <= 8'd158 - {3'd0, lz2_ff};

         tago_ff  <= tag3_ff;
         bits_ff  <= bits_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_bits  = bits_ff;
   assign out_tag   = tago_ff;

endmodule

### tb/int8_batch_dot_product_unit_checker.sv
// ----------------------------------------------------------------------------
// int8 batch dot product unit checker
// tracks lane accumulators, element count and vector length from the req and
// csr channels, queues one float sum per lane at each batch end and compares
// every rsp item and every read of the length register against it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module int8_batch_dot_product_unit_checker #(
   parameter int unsigned LANES = 8
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [71:0]  req_tdata,    // query_element [7:0], data_lanes [71:8]

   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,    // product_sum [31:0]
   input  logic [2:0]   rsp_tuser,    // lane_index [2:0]
   input  logic         rsp_tlast,

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic [31:0]  csr_prdata,
   input  logic         csr_pready,

   output int           mismatches,
   output int           sums_outstanding
);

   localparam logic [2:0] LENGTH_ADDR = {i8dp_pkg::REG_VECTOR_LENGTH, 2'b00};

   typedef struct {
      logic [2:0]  lane_index;
      logic [31:0] product_sum;
      logic        last_result;
   } lane_sum_type;

   lane_sum_type pending_sums[$];
   logic [31:0]  lane_total[LANES];
   logic [16:0]  elements_taken;
   logic [16:0]  cfg_length;
   int           failures = 0;

   // signed 32-bit integer to ieee single, round to nearest even
   function automatic logic [31:0] to_single(input logic [31:0] value);
      logic        sgn;
      logic [31:0] mag;
      logic [31:0] mant;
      logic [31:0] dropped;
      logic [31:0] halfway;
      int          msb;
      int          sh;
      sgn = value[31];
      mag = sgn ? (32'd0 - value) : value;
      if (mag == 32'd0) begin
         return 32'd0;
      end
      msb = 0;
      for (int k = 0; k < 32; k++) begin
         if (mag[k]) begin
            msb = k;
         end
      end
      if (msb <= 23) begin
         mant = mag << (23 - msb);
      end else begin
         sh = msb - 23;
         dropped = mag & ((32'd1 << sh) - 32'd1);
         halfway = 32'd1 << (sh - 1);
         mant = mag >> sh;
         if (dropped > halfway || (dropped == halfway && mant[0])) begin
            mant = mant + 32'd1;
         end
         if (mant[24]) begin
            mant = mant >> 1;
            msb = msb + 1;
         end
      end
      return {sgn, 8'(127 + msb), mant[22:0]};
   endfunction

   always @(posedge clock) begin
      lane_sum_type       want;
      lane_sum_type       got;
      logic signed [7:0]  query;
      logic signed [7:0]  elem;
      logic signed [31:0] prod;
      logic [16:0]        span;
      if (reset) begin
         pending_sums.delete();
         for (int k = 0; k < LANES; k++) begin
            lane_total[k] = 32'd0;
         end
         elements_taken = '0;
         cfg_length = 17'd1;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == LENGTH_ADDR) begin
                  cfg_length = csr_pwdata[16:0];
               end
            end else if (csr_paddr == LENGTH_ADDR && csr_prdata !== {15'd0, cfg_length}) begin
               $error("vector_length: expected %0h, got %0h", {15'd0, cfg_length}, csr_prdata);
               failures++;
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got.lane_index = rsp_tuser;
            got.product_sum = rsp_tdata;
            got.last_result = rsp_tlast;
            if (pending_sums.size() == 0) begin
               $error("unexpected item: lane_index %0d product_sum %08h last_result %0b",
                      got.lane_index, got.product_sum, got.last_result);
               failures++;
            end else begin
               want = pending_sums.pop_front();
               if (got.lane_index !== want.lane_index) begin
                  $error("lane_index: expected %0d, got %0d", want.lane_index, got.lane_index);
                  failures++;
               end
               if (got.product_sum !== want.product_sum) begin
                  $error("product_sum: expected %08h, got %08h",
                         want.product_sum, got.product_sum);
                  failures++;
               end
               if (got.last_result !== want.last_result) begin
                  $error("last_result: expected %0b, got %0b",
                         want.last_result, got.last_result);
                  failures++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            query = req_tdata[7:0];
            for (int k = 0; k < LANES; k++) begin
               elem = req_tdata[8 + 8*k +: 8];
               prod = query * elem;
               lane_total[k] = lane_total[k] + prod;
            end
            elements_taken = elements_taken + 17'd1;
            span = (cfg_length == 17'd0) ? 17'd1 : cfg_length;
            if (elements_taken >= span) begin
               for (int k = 0; k < LANES; k++) begin
                  want.lane_index = 3'(k);
                  want.product_sum = to_single(lane_total[k]);
                  want.last_result = (k == LANES - 1);
                  pending_sums.push_back(want);
                  lane_total[k] = 32'd0;
               end
               elements_taken = '0;
            end
         end
      end
      sums_outstanding <= pending_sums.size();
      mismatches <= failures;
   end

endmodule

### tb/int8_batch_dot_product_unit_test.sv
// ----------------------------------------------------------------------------
// int8 batch dot product unit test
// drives query and lane items with random gaps and a stalling receiver,
// moves the vector length through its extremes, zero and mid-batch changes,
// and holds rsp off once so the unit backs up; the checker predicts every sum
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module int8_batch_dot_product_unit_test;

   localparam int unsigned LANES       = 8;
   localparam logic [2:0]  LENGTH_ADDR = {i8dp_pkg::REG_VECTOR_LENGTH, 2'b00};
   localparam int          IDLE_LIMIT  = 4000;
   localparam int          LONG_HOLD   = 400;
   localparam int          TAIL_CYCLES = 32;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           mismatches;
   int           sums_outstanding;
   int           idle_cycles;
   logic         hold_request;

   int8_batch_dot_product_unit #(.LANES(LANES)) dut (.*);

   int8_batch_dot_product_unit_checker #(.LANES(LANES)) u_checker (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 50);
   endfunction

   task automatic send_item(input logic [7:0] query, input logic [63:0] lanes);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lanes, query};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_item(8'($urandom), {$urandom, $urandom});
   endtask

   // stop offering, wait for every sum, then let the converter go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sums_outstanding != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // write the length, then read it back
   task automatic set_length(input logic [16:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LENGTH_ADDR;
      csr_pwdata <= {15'd0, value};
      @(posedge clock) csr_penable <= 1'b1;
      @(posedge clock) begin
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
      end
      @(posedge clock) csr_penable <= 1'b1;
      @(posedge clock) begin
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
      end
   endtask

   // receiver: random stalls, one long hold when asked
   initial begin
      int stall;
      int run;
      bit held;
      rsp_tready = 1'b0;
      held = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held = 1'b1;
         end else begin
            rsp_tready <= 1'b1;
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(40, 120);
            repeat (run) @(posedge clock);
            stall = $urandom_range(0, 99);
            if (stall < 55) begin
               stall = 0;
            end else if (stall < 92) begin
               stall = $urandom_range(1, 3);
            end else begin
               stall = $urandom_range(8, 40);
            end
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("int8_batch_dot_product_unit_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int          len;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_request = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // length out of reset, field extremes, zero sum, mixed signs
      send_item(8'h80, 64'h8080_8080_8080_8080);
      send_item(8'h7F, 64'h7F7F_7F7F_7F7F_7F7F);
      send_item(8'h80, 64'h7F7F_7F7F_7F7F_7F7F);
      send_item(8'h00, 64'hA5C3_7E01_FF80_5A3C);
      send_item(8'hFF, 64'h807F_01FF_0040_C07F);
      settle();

      // zero length acts as one
      set_length(17'd0);
      send_item(8'h7F, 64'h8000_7F00_0180_FF01);
      send_item(8'h01, 64'hFFFF_FFFF_FFFF_FFFF);
      settle();

      // length above range, then shortened below the count
      set_length(17'd131071);
      send_item(8'h80, 64'h8080_8080_8080_8080);
      send_item(8'h80, 64'h8080_8080_8080_8080);
      send_item(8'h7F, 64'h7F80_7F80_7F80_7F80);
      settle();
      set_length(17'd3);
      send_item(8'h55, 64'h0123_4567_89AB_CDEF);
      settle();

      // top of range, then shortened so the count reaches it
      set_length(17'd65536);
      send_item(8'h80, 64'h7F7F_7F7F_8080_8080);
      send_item(8'hC3, 64'h1234_5678_9ABC_DEF0);
      settle();
      set_length(17'd4);
      send_item(8'h80, 64'h8080_8080_8080_8080);
      send_item(8'h80, 64'h8080_8080_8080_8080);
      settle();

      set_length(17'd2);
      send_item(8'h7F, 64'h8080_8080_8080_8080);
      send_item(8'h80, 64'h8080_8080_8080_8080);
      settle();

      // back up the unit behind a long rsp hold
      set_length(17'd1);
      hold_request <= 1'b1;
      send_random(40);
      settle();

      // several short lengths, batches sometimes left open across a change
      repeat (6) begin
         len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         set_length(17'(len));
         send_random($urandom_range(3, 11));
         settle();
      end

      set_length(17'd1);
      send_random(10);
      settle();

      if (sums_outstanding != 0) begin
         $error("%0d sums never arrived", sums_outstanding);
      end
      if (mismatches == 0 && sums_outstanding == 0) begin
         $display("int8_batch_dot_product_unit_test OK");
      end else begin
         $display("int8_batch_dot_product_unit_test NOT OK");
      end
      $finish;
   end

endmodule
